// File: design/stq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the saturating expiry add of the timer queue
// no dependencies

package stq_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int TIME_BITS   = 48;
    localparam int PERIOD_BITS = 32;
    localparam int DUR_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int PER_W       = (PERIOD_BITS < DUR_BITS) ? PERIOD_BITS : DUR_BITS;
    localparam int SUM_W       = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;

    localparam logic [DUR_BITS-1:0] ONE_MASK =
        (TIME_BITS >= DUR_BITS) ? {DUR_BITS{1'b1}} : DUR_BITS'((65'd1 << TIME_BITS) - 65'd1);
    localparam logic [DUR_BITS-1:0] PER_MASK =
        (PERIOD_BITS >= DUR_BITS) ? {DUR_BITS{1'b1}} : DUR_BITS'((65'd1 << PERIOD_BITS) - 65'd1);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ONESHOT  = 2'd1,
        OP_PERIODIC = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_ZERO_DUR = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_FIRED    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_INSERT,
        S_FINISH
    } state_t;

    typedef struct packed {
        opcode_t                op;
        logic [TIME_BITS-1:0]   now;
        logic [DUR_BITS-1:0]    dur;
        logic [HANDLE_BITS-1:0] handle;
    } item_t;

    // time plus duration, held at the largest time on overflow
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [DUR_BITS-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum[SUM_W-1:TIME_BITS] != '0)
            return {TIME_BITS{1'b1}};
        return sum[TIME_BITS-1:0];
    endfunction

endpackage

// File: design/stq_front.sv
`timescale 1ns / 1ps
// front end: takes items, drops unused opcodes, buffers the rest in a short queue
// depends on stq_pkg

module stq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [stq_pkg::TIME_BITS-1:0]   now_us,
    input  logic [stq_pkg::DUR_BITS-1:0]    duration_us,
    input  logic [stq_pkg::HANDLE_BITS-1:0] handle,
    output logic                         q_valid,
    output stq_pkg::item_t               q_item,
    input  logic                         q_pop
);
    import stq_pkg::*;

    localparam int QD = 2;

    item_t       mem_reg [QD];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        push;

    assign in_stall = (cnt_reg == 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    // unused opcode gives no result, so it never enters the queue
    assign push     = in_valid && !in_stall && (opcode_t'(opcode) != OP_UNUSED);

    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{op: opcode_t'(opcode), now: now_us,
                                     dur: duration_us, handle: handle};
        end
    end

endmodule

// File: design/stq_engine.sv
`timescale 1ns / 1ps
// back end: slot tables, sorted list walk, firing and the result register
// depends on stq_pkg

module stq_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  stq_pkg::item_t                  q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [stq_pkg::SLOT_W-1:0]      slot,
    output logic [stq_pkg::HANDLE_BITS-1:0] fired_handle,
    output logic                            last
);
    import stq_pkg::*;

    logic [TIME_BITS-1:0]   exp_mem [SLOTS];
    logic [PER_W-1:0]       per_mem [SLOTS];
    logic [HANDLE_BITS-1:0] cb_mem  [SLOTS];
    logic [SLOT_W-1:0]      order_reg [SLOTS];
    logic [SLOT_W-1:0]      order_next [SLOTS];

    state_t                 state_reg, state_next;
    logic [SLOTS-1:0]       busy_reg, busy_next;
    logic [SLOTS-1:0]       fired_reg, fired_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [SLOT_W-1:0]      ins_slot_reg, ins_slot_next;
    logic [TIME_BITS-1:0]   ins_exp_reg, ins_exp_next;
    logic                   is_tick_reg, is_tick_next;
    logic                   pend_valid_reg, pend_valid_next;
    status_t                pend_status_reg, pend_status_next;
    logic [SLOT_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [HANDLE_BITS-1:0] pend_handle_reg, pend_handle_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   emit;
    logic                   emit_last;
    logic [SLOT_W-1:0]      rd_addr;
    logic [TIME_BITS-1:0]   rd_exp;
    logic [SLOT_W-1:0]      head;
    logic [SLOT_W-1:0]      free_slot;
    logic                   all_busy;
    logic [DUR_BITS-1:0]    d;
    logic                   adv;
    logic                   head_stop;
    logic                   head_fire;
    logic [TIME_BITS-1:0]   rearm_exp;

    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_addr;
    logic [TIME_BITS-1:0]   mem_exp;
    logic                   start_we;

    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot         = out_slot_reg;
    assign fired_handle = out_handle_reg;
    assign last         = out_last_reg;

    assign head    = order_reg[0];
    assign rd_addr = (state_reg == S_INSERT) ? order_reg[pos_reg[SLOT_W-1:0]] : head;
    assign rd_exp  = exp_mem[rd_addr];

    always_comb
    begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
                free_slot = SLOT_W'(i);
        end
    end

    assign all_busy  = &busy_reg;
    assign d         = (q_item.op == OP_PERIODIC) ? (q_item.dur & PER_MASK)
                                                  : (q_item.dur & ONE_MASK);
    assign adv       = (pos_reg < count_reg) && (rd_exp <= ins_exp_reg);
    assign head_stop = (count_reg == '0) || fired_reg[head] || (now_reg < rd_exp);
    assign head_fire = !head_stop && (!pend_valid_reg || out_free);
    assign rearm_exp = sat_add(rd_exp, DUR_BITS'(per_mem[head]));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == OP_TICK)
                        state_next = S_HEAD;
                    else if (d == '0 || all_busy)
                        state_next = S_FINISH;
                    else
                        state_next = S_INSERT;
                end
            end
            S_HEAD:
            begin
                if (head_stop)
                    state_next = S_FINISH;
                else if (head_fire && per_mem[head] != '0)
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (!adv)
                    state_next = is_tick_reg ? S_HEAD : S_FINISH;
            end
            S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop            = 1'b0;
        emit             = 1'b0;
        emit_last        = 1'b0;
        busy_next        = busy_reg;
        fired_next       = fired_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        now_next         = now_reg;
        ins_slot_next    = ins_slot_reg;
        ins_exp_next     = ins_exp_reg;
        is_tick_next     = is_tick_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_handle_next = pend_handle_reg;
        order_next       = order_reg;
        mem_we           = 1'b0;
        mem_addr         = head;
        mem_exp          = rearm_exp;
        start_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    fired_next      = '0;
                    now_next        = q_item.now;
                    is_tick_next    = (q_item.op == OP_TICK);
                    pend_valid_next = 1'b0;
                    pos_next        = '0;
                    if (q_item.op != OP_TICK)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_slot_next   = '0;
                        pend_handle_next = '0;
                        if (d == '0)
                            pend_status_next = ST_ZERO_DUR;
                        else if (all_busy)
                            pend_status_next = ST_NO_SLOT;
                        else
                        begin
                            pend_status_next    = ST_STARTED;
                            pend_slot_next      = free_slot;
                            pend_handle_next    = q_item.handle;
                            busy_next[free_slot] = 1'b1;
                            start_we            = 1'b1;
                            mem_we              = 1'b1;
                            mem_addr            = free_slot;
                            mem_exp             = sat_add(q_item.now, d);
                            ins_slot_next       = free_slot;
                            ins_exp_next        = sat_add(q_item.now, d);
                        end
                    end
                end
            end
            S_HEAD:
            begin
                if (head_fire)
                begin
                    emit             = pend_valid_reg;
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_FIRED;
                    pend_slot_next   = head;
                    pend_handle_next = cb_mem[head];
                    fired_next[head] = 1'b1;
                    for (int i = 0; i < SLOTS - 1; i++)
                        order_next[i] = order_reg[i+1];
                    count_next = count_reg - CNT_W'(1);
                    if (per_mem[head] != '0)
                    begin
                        mem_we        = 1'b1;
                        ins_slot_next = head;
                        ins_exp_next  = rearm_exp;
                        pos_next      = '0;
                    end
                    else
                    begin
                        busy_next[head] = 1'b0;
                    end
                end
            end
            S_INSERT:
            begin
                if (adv)
                    pos_next = pos_reg + CNT_W'(1);
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (CNT_W'(i) == pos_reg)
                            order_next[i] = ins_slot_reg;
                        else if (CNT_W'(i) > pos_reg)
                            order_next[i] = order_reg[i-1];
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg       <= fired_next;
        pos_reg         <= pos_next;
        now_reg         <= now_next;
        ins_slot_reg    <= ins_slot_next;
        ins_exp_reg     <= ins_exp_next;
        is_tick_reg     <= is_tick_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_handle_reg <= pend_handle_next;
        order_reg       <= order_next;
        if (emit)
        begin
            out_status_reg <= pend_status_reg;
            out_slot_reg   <= pend_slot_reg;
            out_handle_reg <= pend_handle_reg;
            out_last_reg   <= emit_last;
        end
    end

    // slot tables
    always_ff @(posedge clk)
    begin
        if (mem_we)
            exp_mem[mem_addr] <= mem_exp;
        if (start_we)
        begin
            cb_mem[free_slot]  <= q_item.handle;
            per_mem[free_slot] <= (q_item.op == OP_PERIODIC) ? d[PER_W-1:0] : '0;
        end
    end

endmodule

// File: design/sorted_timer_queue.sv
`timescale 1ns / 1ps
// timer queue of 16 slots kept in a list sorted by expiry, one-shot and periodic
// start: a rejected item skips the insertion walk; a taken one is placed by it, one slot per cycle
// tick: each due slot fires from the list head; a periodic slot is then re-inserted by the same walk
// items queue two deep ahead of the engine; one item is worked at a time
// reset clears busy flags, list count and handshake state; slot tables need none
// depends on stq_pkg, stq_front, stq_engine

module sorted_timer_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [stq_pkg::TIME_BITS-1:0]   now_us,
    input  logic [stq_pkg::DUR_BITS-1:0]    duration_us,
    input  logic [stq_pkg::HANDLE_BITS-1:0] handle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [stq_pkg::SLOT_W-1:0]      slot,
    output logic [stq_pkg::HANDLE_BITS-1:0] fired_handle,
    output logic                            last
);
    import stq_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    stq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .now_us      (now_us),
        .duration_us (duration_us),
        .handle      (handle),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    stq_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .fired_handle (fired_handle),
        .last         (last)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench of the sorted timer queue: one-shot and periodic starts, ticks, full queue, back pressure, random items
// depends on stq_pkg and sorted_timer_queue

module tb_top;
    import stq_pkg::*;

    typedef struct {
        logic [1:0]             status;
        logic [SLOT_W-1:0]      slot;
        logic [HANDLE_BITS-1:0] hnd;
        logic                   last;
    } timer_event_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             opcode;
    logic [TIME_BITS-1:0]   now_us;
    logic [DUR_BITS-1:0]    duration_us;
    logic [HANDLE_BITS-1:0] handle;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [SLOT_W-1:0]      slot;
    logic [HANDLE_BITS-1:0] fired_handle;
    logic                   last;

    // own copy of the timer tables
    logic [TIME_BITS-1:0]   exp_tab [SLOTS];
    logic [TIME_BITS-1:0]   per_tab [SLOTS];
    logic [HANDLE_BITS-1:0] cb_tab  [SLOTS];
    logic                   busy_tab[SLOTS];
    int                     order_q [$];

    timer_event_t           pending_events[$];
    int                     errors;
    int                     cycles;
    logic [TIME_BITS-1:0]   clock_now;
    bit                     gaps_on;
    bit                     hold_rx;
    int                     stall_pct;

    sorted_timer_queue uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .now_us(now_us), .duration_us(duration_us), .handle(handle),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .slot(slot),
        .fired_handle(fired_handle), .last(last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [TIME_BITS-1:0] add_capped(logic [TIME_BITS-1:0] a,
                                                        logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    // insert after equal expiries
    task automatic place_slot(int s);
        int pos;
        pos = 0;
        while (pos < order_q.size() && exp_tab[order_q[pos]] <= exp_tab[s])
            pos++;
        order_q.insert(pos, s);
    endtask

    task automatic push_event(logic [1:0] st, int s, logic [HANDLE_BITS-1:0] h, bit lst);
        timer_event_t e;
        e.status = st;
        e.slot = SLOT_W'(s);
        e.hnd = h;
        e.last = lst;
        pending_events.push_back(e);
    endtask

    task automatic predict_timer(logic [1:0] op, logic [TIME_BITS-1:0] now,
                                 logic [DUR_BITS-1:0] dur, logic [HANDLE_BITS-1:0] h);
        logic [TIME_BITS-1:0] d;
        bit                   done_now[SLOTS];
        int                   s;
        int                   n;
        if (op == OP_ONESHOT || op == OP_PERIODIC) begin
            d = TIME_BITS'(op == OP_PERIODIC ? (dur & PER_MASK) : (dur & ONE_MASK));
            if (d == 0) begin
                push_event(ST_ZERO_DUR, 0, '0, 1'b1);
                return;
            end
            s = 0;
            while (s < SLOTS && busy_tab[s])
                s++;
            if (s == SLOTS) begin
                push_event(ST_NO_SLOT, 0, '0, 1'b1);
                return;
            end
            busy_tab[s] = 1'b1;
            cb_tab[s] = h;
            per_tab[s] = (op == OP_PERIODIC) ? d : '0;
            exp_tab[s] = add_capped(now, d);
            place_slot(s);
            push_event(ST_STARTED, s, h, 1'b1);
        end else if (op == OP_TICK) begin
            foreach (done_now[i])
                done_now[i] = 1'b0;
            n = 0;
            while (order_q.size() > 0) begin
                s = order_q[0];
                if (done_now[s] || now < exp_tab[s])
                    break;
                done_now[s] = 1'b1;
                push_event(ST_FIRED, s, cb_tab[s], 1'b0);
                n++;
                void'(order_q.pop_front());
                if (per_tab[s] != 0) begin
                    exp_tab[s] = add_capped(exp_tab[s], per_tab[s]);
                    place_slot(s);
                end else begin
                    busy_tab[s] = 1'b0;
                end
            end
            if (n > 0)
                pending_events[$].last = 1'b1;
        end
    endtask

    // valid drops only in an idle cycle, so it is never written twice at one edge
    task automatic send_item(logic [1:0] op, logic [TIME_BITS-1:0] now,
                             logic [DUR_BITS-1:0] dur, logic [HANDLE_BITS-1:0] h);
        while (gaps_on && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        now_us <= now;
        duration_us <= dur;
        handle <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_timer(op, now, dur, h);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(OP_ONESHOT, 48'd100, 32'd0, 16'hFFFF);
        send_item(OP_PERIODIC, 48'd100, 32'd0, 16'h1234);
        send_item(OP_TICK, 48'd0, 32'd0, 16'd0);
        send_item(OP_ONESHOT, 48'd100, 32'd50, 16'hFFFF);
        send_item(OP_ONESHOT, 48'd100, 32'd50, 16'h0001);
        send_item(OP_PERIODIC, 48'd100, 32'd20, 16'hA5A5);
        send_item(OP_ONESHOT, {TIME_BITS{1'b1}}, 32'hFFFF_FFFF, 16'h5A5A);
        send_item(OP_PERIODIC, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF, 16'h0F0F);
        send_item(OP_UNUSED, 48'd999, 32'd7, 16'd7);
        send_item(OP_TICK, 48'd119, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_TICK, 48'd120, 32'd0, 16'd0);
        // periodic slot is due again but stays behind within one tick
        send_item(OP_TICK, 48'd1000, 32'd0, 16'd0);
        send_item(OP_TICK, {TIME_BITS{1'b1}}, 32'd0, 16'd0);
        send_item(OP_TICK, {TIME_BITS{1'b1}}, 32'd0, 16'd0);
        wait_drained();
    endtask

    // fill every slot, overflow, then fire them all in one tick
    task automatic test_full_queue();
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(OP_ONESHOT, 48'd5000, DUR_BITS'($urandom_range(1, 4)), 16'($urandom));
        send_item(OP_PERIODIC, 48'd5000, 32'd3, 16'd9);
        send_item(OP_TICK, {TIME_BITS{1'b1}} - 1, 32'd0, 16'd0);
        send_item(OP_TICK, {TIME_BITS{1'b1}}, 32'd0, 16'd0);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_back_pressure();
        hold_rx = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(OP_ONESHOT, 48'd10, 32'd0, 16'(i));
        hold_rx = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        logic [1:0]           op;
        logic [DUR_BITS-1:0]  dur;
        int                   r;
        clock_now = 48'd100000;
        for (int i = 0; i < 84; i++) begin
            gaps_on = (i < 25 || i > 50);
            r = $urandom_range(99);
            op = (r < 40) ? OP_TICK : (r < 65) ? OP_ONESHOT : (r < 97) ? OP_PERIODIC
                 : OP_UNUSED;
            r = $urandom_range(99);
            dur = (r < 80) ? DUR_BITS'($urandom_range(1, 300))
                : (r < 90) ? $urandom : (r < 95) ? '0 : 32'h0000_0100;
            if (op == OP_TICK)
                clock_now = clock_now + TIME_BITS'($urandom_range(0, 250));
            if (i == 75)
                clock_now = {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(0, 500));
            send_item(op, ($urandom_range(19) == 0) ? TIME_BITS'({$urandom, $urandom})
                                                    : clock_now,
                      dur, 16'($urandom));
            if (i == 60)
                wait_drained();
        end
        send_item(OP_TICK, {TIME_BITS{1'b1}}, 32'd0, 16'd0);
        send_item(OP_TICK, {TIME_BITS{1'b1}}, 32'd0, 16'd0);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // result checker
    always @(posedge clk) begin
        timer_event_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d", $time, status, slot);
                errors++;
            end else begin
                e = pending_events.pop_front();
                if (status !== e.status || slot !== e.slot || fired_handle !== e.hnd
                    || last !== e.last) begin
                    $display("%0t: expected st %0d slot %0d hnd %h last %0d, got %0d %0d %h %0d",
                             $time, e.status, e.slot, e.hnd, e.last,
                             status, slot, fired_handle, last);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with a long hold-off counted here
    always @(posedge clk) begin
        int hold_cnt;
        if (hold_rx && hold_cnt < 300) begin
            hold_cnt++;
            out_stall <= 1'b1;
        end else begin
            out_stall <= gaps_on ? ($urandom_range(99) < stall_pct) : 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        gaps_on = 1'b1;
        hold_rx = 1'b0;
        stall_pct = 33;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = OP_TICK;
        now_us = '0;
        duration_us = '0;
        handle = '0;
        foreach (busy_tab[i])
            busy_tab[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_queue();
        test_back_pressure();
        test_random();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
design/stq_pkg.sv
design/stq_front.sv
design/stq_engine.sv
design/sorted_timer_queue.sv
tb/tb_top.sv
